/* hw/rtl/drmg_pkg.sv */
// ============================================================================
// drmg_pkg
// Shared types and constants for the dirty-rectangle region merger.
// ============================================================================
package drmg_pkg;

    // Fixed field widths of the transaction payloads
    localparam int COORD_W = 16;
    localparam int COUNT_W = 6;

    // Command codes; code 3 has no meaning and is treated as a no-op
    typedef enum logic [1:0] {
        CMD_ADD_BOTH = 2'd0,
        CMD_ADD_COMP = 2'd1,
        CMD_CLEAR    = 2'd2
    } t_cmd;

    // Input transaction
    typedef struct packed {
        logic        [1:0]         cmd;
        logic signed [COORD_W-1:0] rect_left;
        logic signed [COORD_W-1:0] rect_top;
        logic signed [COORD_W-1:0] rect_right;
        logic signed [COORD_W-1:0] rect_bottom;
    } t_in_item;

    // Output transaction
    typedef struct packed {
        logic signed [COORD_W-1:0] damage_left;
        logic signed [COORD_W-1:0] damage_top;
        logic signed [COORD_W-1:0] damage_right;
        logic signed [COORD_W-1:0] damage_bottom;
        logic                      damage_valid;
        logic        [COUNT_W-1:0] comp_count;
        logic        [COUNT_W-1:0] raster_count;
        logic                      comp_collapsed;
        logic                      raster_collapsed;
    } t_out_item;

    // Control from the top level to one list
    typedef struct packed {
        logic start;
        logic clear;
    } t_list_ctrl;

    // Status from one list back to the top level
    typedef struct packed {
        logic busy;
        logic collapsed;
    } t_list_stat;

endpackage

/* hw/rtl/drmg_cell.sv */
// ============================================================================
// drmg_cell
// One storage cell of a rectangle list: holds one packed box, loads a new
// box or takes its upper neighbor's box when the list closes up.
// ============================================================================
module drmg_cell #(
    parameter int W = 64
) (
    input  logic         i_clk,
    input  logic         i_shift,
    input  logic         i_load,
    input  logic [W-1:0] i_load_box,
    input  logic [W-1:0] i_next_box,
    output logic [W-1:0] o_box
);

    logic [W-1:0] r_box;

    // Box register; load wins, then close-up shift from the neighbor
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_box <= i_load_box;
        end else if (i_shift) begin
            r_box <= i_next_box;
        end
    end

    assign o_box = r_box;

endmodule

/* hw/rtl/drmg_list.sv */
// ============================================================================
// drmg_list
// One ordered rectangle list as a row of cells. A merge walks a position
// pointer up the row; an absorbed entry is removed by shifting the cells
// above it down one place, so the list stays packed from cell 0.
// ============================================================================
module drmg_list
    import drmg_pkg::*;
#(
    parameter int MAX_REGIONS = 32,
    parameter int CB          = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  t_list_ctrl                         i_ctrl,
    input  logic [4*CB-1:0]                    i_box,
    output t_list_stat                         o_stat,
    output logic [$clog2(MAX_REGIONS+1)-1:0]   o_fill,
    output logic [4*CB-1:0]                    o_union
);

    localparam int CW = $clog2(MAX_REGIONS + 1);
    localparam int BW = 4 * CB;

    typedef struct packed {
        logic signed [CB-1:0] l;
        logic signed [CB-1:0] t;
        logic signed [CB-1:0] r;
        logic signed [CB-1:0] b;
    } t_box;

    typedef enum logic {
        S_IDLE,
        S_WALK
    } t_state;

    function automatic t_box join_box(input t_box a, input t_box b);
        t_box u;
        u.l = (a.l < b.l) ? a.l : b.l;
        u.t = (a.t < b.t) ? a.t : b.t;
        u.r = (a.r > b.r) ? a.r : b.r;
        u.b = (a.b > b.b) ? a.b : b.b;
        return u;
    endfunction

    function automatic logic overlaps(input t_box a, input t_box b);
        return (a.l < b.r) && (b.l < a.r) && (a.t < b.b) && (b.t < a.b);
    endfunction

    t_state          r_state;
    logic [CW-1:0]   r_pos;
    logic [CW-1:0]   r_fill;
    t_box            r_merged;
    t_box            r_kept;
    t_box            r_union;
    logic            r_collapsed;

    logic [BW-1:0]   cell_box [MAX_REGIONS];
    logic [MAX_REGIONS-1:0] cell_shift;
    logic [MAX_REGIONS-1:0] cell_load;
    t_box            cur;
    t_box            final_box;
    t_box            load_box;
    logic            walking;
    logic            at_end;
    logic            full;
    logic            hit;
    logic            absorb;
    logic            advance;
    logic            finish;

    // Entry under the walk pointer
    always_comb begin
        cur = '0;
        for (int j = 0; j < MAX_REGIONS; j++) begin
            if (r_pos == CW'(j)) begin
                cur = t_box'(cell_box[j]);
            end
        end
    end

    // Walk step decode
    assign walking   = (r_state == S_WALK);
    assign at_end    = (r_pos == r_fill);
    assign full      = (r_pos == CW'(MAX_REGIONS));
    assign hit       = overlaps(r_merged, cur);
    assign absorb    = walking && !at_end && hit;
    assign advance   = walking && !at_end && !hit;
    assign finish    = walking && at_end;
    assign final_box = (r_pos == '0) ? r_merged : join_box(r_kept, r_merged);
    assign load_box  = full ? final_box : r_merged;

    // Per-cell shift and load enables
    always_comb begin
        for (int j = 0; j < MAX_REGIONS; j++) begin
            cell_shift[j] = absorb && (CW'(j) >= r_pos);
            cell_load[j]  = finish && (full ? (j == 0) : (CW'(j) == r_pos));
        end
    end

    // Row of cells, each fed by its upper neighbor (the top cell by itself)
    for (genvar g = 0; g < MAX_REGIONS; g++) begin : g_cell
        drmg_cell #(
            .W (BW)
        ) u_cell (
            .i_clk      (i_clk),
            .i_shift    (cell_shift[g]),
            .i_load     (cell_load[g]),
            .i_load_box (load_box),
            .i_next_box (cell_box[(g < MAX_REGIONS - 1) ? g + 1 : g]),
            .o_box      (cell_box[g])
        );
    end

    // Merge sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pos       <= '0;
            r_fill      <= '0;
            r_collapsed <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_ctrl.clear) begin
                        r_fill <= '0;
                    end
                    if (i_ctrl.start) begin
                        r_merged    <= t_box'(i_box);
                        r_pos       <= '0;
                        r_collapsed <= 1'b0;
                        r_state     <= S_WALK;
                    end
                end
                S_WALK: begin
                    if (at_end) begin
                        // append, or collapse when nothing was absorbed on a full list
                        r_fill      <= full ? CW'(1) : r_pos + CW'(1);
                        r_union     <= final_box;
                        r_collapsed <= full;
                        r_state     <= S_IDLE;
                    end else if (hit) begin
                        r_merged <= join_box(r_merged, cur);
                        r_fill   <= r_fill - CW'(1);
                    end else begin
                        r_kept <= (r_pos == '0) ? cur : join_box(r_kept, cur);
                        r_pos  <= r_pos + CW'(1);
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_stat.busy      = walking;
    assign o_stat.collapsed = r_collapsed;
    assign o_fill           = r_fill;
    assign o_union          = BW'(r_union);

    // Fill count never exceeds the row length
    a_fill_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= CW'(MAX_REGIONS))
        else $error("list fill beyond capacity");

    // Walk pointer never passes the end of the packed list
    a_pos_le_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        walking |-> (r_pos <= r_fill))
        else $error("walk pointer past list end");

    // A finished walk leaves a non-empty list and an idle sequencer
    a_finish_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        finish |=> (r_fill != '0) && (r_state == S_IDLE))
        else $error("merge finished with empty list");

endmodule

/* hw/rtl/dirty_rect_region_merger_top.sv */
// ============================================================================
// dirty_rect_region_merger_top
// Dirty-rectangle damage region merger with compositing and raster lists.
// ============================================================================
// Each list is a row of cells; an add walks it one entry per cycle,
// absorbing an overlapping entry by shifting the row down or stepping
// past a kept one. An add to both lists walks the two side by side; an
// add to the compositing list walks that list alone. Clear, empty-
// rectangle and unused commands start no walk. One command is in work at
// a time; the next is accepted as soon as its result sits in the output
// register, even if that result has not been taken yet. No clearing pass
// follows reset.
module dirty_rect_region_merger_top
    import drmg_pkg::*;
#(
    parameter int MAX_REGIONS = 32,
    parameter int COORD_BITS  = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_item
);

    localparam int CW = $clog2(MAX_REGIONS + 1);
    localparam int CB = COORD_BITS;

    typedef struct packed {
        logic signed [CB-1:0] l;
        logic signed [CB-1:0] t;
        logic signed [CB-1:0] r;
        logic signed [CB-1:0] b;
    } t_box;

    typedef enum logic {
        S_IDLE,
        S_RUN
    } t_state;

    t_state      r_state;
    logic        r_walk_comp;
    logic        r_walk_raster;
    logic        r_out_valid;
    t_out_item   r_out_item;

    t_box        in_box;
    t_box        comp_box;
    t_box        raster_box;
    logic        accept_in;
    logic        out_free;
    logic        result_load;
    logic        nonempty;
    logic        is_add;
    logic        lists_idle;
    t_list_ctrl  comp_ctrl;
    t_list_ctrl  raster_ctrl;
    t_list_stat  comp_stat;
    t_list_stat  raster_stat;
    logic [CW-1:0]   comp_fill;
    logic [CW-1:0]   raster_fill;
    logic [4*CB-1:0] comp_union;
    logic [4*CB-1:0] raster_union;

    // Input rectangle, low COORD_BITS bits taken as signed
    assign in_box.l = i_in_item.rect_left[CB-1:0];
    assign in_box.t = i_in_item.rect_top[CB-1:0];
    assign in_box.r = i_in_item.rect_right[CB-1:0];
    assign in_box.b = i_in_item.rect_bottom[CB-1:0];

    // Command decode at accept
    assign accept_in = i_in_valid && !o_in_stall;
    assign nonempty  = (in_box.r > in_box.l) && (in_box.b > in_box.t);
    assign is_add    = (i_in_item.cmd == CMD_ADD_BOTH) || (i_in_item.cmd == CMD_ADD_COMP);

    assign comp_ctrl.start   = accept_in && is_add && nonempty;
    assign comp_ctrl.clear   = accept_in && (i_in_item.cmd == CMD_CLEAR);
    assign raster_ctrl.start = accept_in && (i_in_item.cmd == CMD_ADD_BOTH) && nonempty;
    assign raster_ctrl.clear = comp_ctrl.clear;

    drmg_list #(
        .MAX_REGIONS (MAX_REGIONS),
        .CB          (CB)
    ) u_comp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (comp_ctrl),
        .i_box   (in_box),
        .o_stat  (comp_stat),
        .o_fill  (comp_fill),
        .o_union (comp_union)
    );

    drmg_list #(
        .MAX_REGIONS (MAX_REGIONS),
        .CB          (CB)
    ) u_raster (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (raster_ctrl),
        .i_box   (in_box),
        .o_stat  (raster_stat),
        .o_fill  (raster_fill),
        .o_union (raster_union)
    );

    assign comp_box    = t_box'(comp_union);
    assign raster_box  = t_box'(raster_union);
    assign lists_idle  = !comp_stat.busy && !raster_stat.busy;
    assign out_free    = !r_out_valid || !i_out_stall;
    assign result_load = (r_state == S_RUN) && lists_idle && out_free;

    // Command sequencer and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_walk_comp   <= 1'b0;
            r_walk_raster <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            if (result_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (accept_in) begin
                        r_walk_comp   <= comp_ctrl.start;
                        r_walk_raster <= raster_ctrl.start;
                        r_state       <= S_RUN;
                    end
                end
                S_RUN: begin
                    if (result_load) begin
                        if (comp_fill != '0) begin
                            r_out_item.damage_left   <= COORD_W'(comp_box.l);
                            r_out_item.damage_top    <= COORD_W'(comp_box.t);
                            r_out_item.damage_right  <= COORD_W'(comp_box.r);
                            r_out_item.damage_bottom <= COORD_W'(comp_box.b);
                        end else begin
                            r_out_item.damage_left   <= '0;
                            r_out_item.damage_top    <= '0;
                            r_out_item.damage_right  <= '0;
                            r_out_item.damage_bottom <= '0;
                        end
                        r_out_item.damage_valid     <= (comp_fill != '0);
                        r_out_item.comp_count       <= COUNT_W'(comp_fill);
                        r_out_item.raster_count     <= COUNT_W'(raster_fill);
                        r_out_item.comp_collapsed   <= r_walk_comp && comp_stat.collapsed;
                        r_out_item.raster_collapsed <= r_walk_raster && raster_stat.collapsed;
                        r_state                     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    // Both lists are idle whenever a new command can be taken
    a_idle_lists: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_stall |-> lists_idle)
        else $error("list busy while accepting commands");

    // Raster list only walks alongside the compositing list
    a_raster_with_comp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        raster_ctrl.start |-> comp_ctrl.start)
        else $error("raster walk without compositing walk");

    // A completed command always raises the output valid
    a_result_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        result_load |=> o_out_valid)
        else $error("command completed without result");

    // An idle non-empty raster list bounds a non-empty box
    a_raster_union: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !raster_stat.busy && (raster_fill != '0) |->
            (raster_box.r > raster_box.l) && (raster_box.b > raster_box.t))
        else $error("raster union is empty");

endmodule
